>>> rtl/eptev_pkg.sv
// ----------------------------------------------------------------------------
// eptev_pkg: shared types and constants for the ellipse point/tangent block
// widths, polynomial coefficients, pipeline token struct
// ----------------------------------------------------------------------------
package eptev_pkg;
	localparam int CoordWidth = 20;
	localparam int AngleWidth = 16;
	localparam int FracBits   = 22;
	localparam int CfgIdxWidth = 2;
	localparam int CfgWidth   = 3 * CoordWidth;

	localparam logic [CfgIdxWidth-1:0] REG_ORIGIN = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_MAJOR  = 2'd1;
	localparam logic [CfgIdxWidth-1:0] REG_MINOR  = 2'd2;

	localparam logic [31:0] K1 = 32'd1686629713;
	localparam logic [31:0] K3 = 32'd693598668;
	localparam logic [31:0] K5 = 32'd85569306;
	localparam logic [31:0] K7 = 32'd5026995;
	localparam logic [31:0] K9 = 32'd172272;

	// one polynomial cell works on both quarter sines in parallel
	typedef struct packed {
		logic        vld;
		logic [1:0]  quad;
		logic [22:0] xa;   // x, up to 2^22
		logic [22:0] xb;   // 2^22 - x
		logic [21:0] ta;   // x*x >> 22
		logic [21:0] tb;
		logic [31:0] aa;   // horner accumulators
		logic [31:0] ab;
	} horner_tok_t;

	function automatic logic [31:0] horner_step(input logic [31:0] k, input logic [31:0] a,
			input logic [21:0] t2);
		logic [53:0] p;
		p = a * t2;
		return k - p[53:22];
	endfunction
endpackage

>>> rtl/eptev_cell.sv
// ----------------------------------------------------------------------------
// eptev_cell: one horner cell of the sine chain
// applies a = k - a*t2 >> 22 to both lanes, passes token to the next cell
// ----------------------------------------------------------------------------
module eptev_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           k,
	input  eptev_pkg::horner_tok_t tok_in,
	output eptev_pkg::horner_tok_t tok_out
);
	import eptev_pkg::*;

	horner_tok_t tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld  <= tok_in.vld;
			tok_q.quad <= tok_in.quad;
			tok_q.xa   <= tok_in.xa;
			tok_q.xb   <= tok_in.xb;
			tok_q.ta   <= tok_in.ta;
			tok_q.tb   <= tok_in.tb;
			tok_q.aa   <= horner_step(k, tok_in.aa, tok_in.ta);
			tok_q.ab   <= horner_step(k, tok_in.ab, tok_in.tb);
		end
	end

	assign tok_out = tok_q;
endmodule

>>> rtl/eptev_axis.sv
// ----------------------------------------------------------------------------
// eptev_axis: one coordinate lane of the output stage
// products of the axis terms with cos/sin, q30 rounding, saturation
// ----------------------------------------------------------------------------
module eptev_axis (
	input  logic                                clk,
	input  logic signed [eptev_pkg::CoordWidth-1:0] o,
	input  logic signed [eptev_pkg::CoordWidth-1:0] a,
	input  logic signed [eptev_pkg::CoordWidth-1:0] b,
	input  logic signed [31:0]                   c,
	input  logic signed [31:0]                   s,
	output logic signed [eptev_pkg::CoordWidth-1:0] pnt,
	output logic signed [eptev_pkg::CoordWidth-1:0] tan
);
	import eptev_pkg::*;

	localparam int PW = CoordWidth + 32;

	logic signed [PW-1:0] ac_s1, bs_s1, bc_s1, as_s1;
	logic signed [CoordWidth-1:0] o_s1;
	logic signed [PW+1:0] psum, tsum;
	logic signed [PW-29:0] pr, tr;
	logic signed [PW-28:0] pfull;

	always_ff @(posedge clk) begin
		ac_s1 <= a * c;
		bs_s1 <= b * s;
		bc_s1 <= b * c;
		as_s1 <= a * s;
		o_s1  <= o;
	end

	function automatic logic signed [CoordWidth-1:0] sat(input logic signed [PW-28:0] v);
		logic signed [PW-28:0] hi, lo;
		hi = (PW-27)'((1 <<< (CoordWidth-1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[CoordWidth-1:0];
		else if (v < lo) return lo[CoordWidth-1:0];
		else return v[CoordWidth-1:0];
	endfunction

	always_comb begin
		psum  = (PW+2)'(ac_s1) + (PW+2)'(bs_s1) + (PW+2)'(1 <<< 29);
		tsum  = (PW+2)'(bc_s1) - (PW+2)'(as_s1) + (PW+2)'(1 <<< 29);
		pr    = psum[PW+1:30];
		tr    = tsum[PW+1:30];
		pfull = (PW-27)'(pr) + (PW-27)'(o_s1);
	end

	always_ff @(posedge clk) begin
		pnt <= sat(pfull);
		tan <= sat((PW-27)'(tr));
	end
endmodule

>>> rtl/ellipse_point_tangent_eval.sv
// ----------------------------------------------------------------------------
// ellipse_point_tangent_eval: point and tangent on a 3d parametric ellipse
// cos/sin by a chain of horner cells, then per-axis multiply and saturate
// ----------------------------------------------------------------------------
// channel   signals                       direction  notes
// command   start, busy, angle            in         beat when start & !busy
// config    cfg_valid/ready/index/data    in         always ready
// result    done, point_*, tangent_*      out        one-cycle strobe
//
// one angle per cycle; the registered stages in order are square, four horner cells,
// final multiply, quadrant mux, products, sum/saturate.
// busy is tied low; the receiver cannot stall so nothing backs up.
// reset clears the config registers and the valid chain.
module ellipse_point_tangent_eval (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [eptev_pkg::AngleWidth-1:0]        angle,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [eptev_pkg::CfgIdxWidth-1:0]       cfg_index,
	input  logic [eptev_pkg::CfgWidth-1:0]          cfg_data,
	output logic                                   done,
	output logic signed [eptev_pkg::CoordWidth-1:0] point_x,
	output logic signed [eptev_pkg::CoordWidth-1:0] point_y,
	output logic signed [eptev_pkg::CoordWidth-1:0] point_z,
	output logic signed [eptev_pkg::CoordWidth-1:0] tangent_x,
	output logic signed [eptev_pkg::CoordWidth-1:0] tangent_y,
	output logic signed [eptev_pkg::CoordWidth-1:0] tangent_z
);
	import eptev_pkg::*;

	logic [CfgWidth-1:0] origin_q, major_q, minor_q;
	logic [23:0] phase;
	logic [22:0] xa, xb;
	logic [1:0]  quad_s1;
	logic        vld_s1;
	logic [22:0] xa_s1, xb_s1;
	logic [45:0] sqa, sqb;
	horner_tok_t tok [0:4];
	logic [31:0] kk [0:3];
	logic [54:0] fa, fb;
	logic [30:0] sa, sb;
	logic signed [31:0] cos_s7, sin_s7;
	logic [1:0]  quad_s6;
	logic        vld_s6, vld_s7;
	logic [30:0] sa_s6, sb_s6;
	logic [1:0]  vld_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			major_q  <= '0;
			minor_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN: origin_q <= cfg_data;
				REG_MAJOR:  major_q  <= cfg_data;
				REG_MINOR:  minor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase = 24'(angle) << (24 - AngleWidth);
		xa    = {1'b0, phase[21:0]};
		xb    = 23'(1 << FracBits) - xa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		quad_s1 <= phase[23:22];
		xa_s1   <= xa;
		xb_s1   <= xb;
	end

	// square of x feeds every horner cell
	always_comb begin
		sqa = xa_s1 * xa_s1;
		sqb = xb_s1 * xb_s1;
		tok[0].vld  = vld_s1;
		tok[0].quad = quad_s1;
		tok[0].xa   = xa_s1;
		tok[0].xb   = xb_s1;
		tok[0].ta   = sqa[43:22];
		tok[0].tb   = sqb[43:22];
		tok[0].aa   = K9;
		tok[0].ab   = K9;
	end

	assign kk[0] = K7;
	assign kk[1] = K5;
	assign kk[2] = K3;
	assign kk[3] = K1;

	for (genvar g = 0; g < 4; g++) begin : g_chain
		eptev_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.k      (kk[g]),
			.tok_in (tok[g]),
			.tok_out(tok[g+1])
		);
	end

	always_comb begin
		fa = tok[4].aa * tok[4].xa;
		fb = tok[4].ab * tok[4].xb;
		sa = (fa[54:22] > 33'(1 << 30)) ? 31'(1 << 30) : fa[52:22];
		sb = (fb[54:22] > 33'(1 << 30)) ? 31'(1 << 30) : fb[52:22];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_d  <= '0;
		end else begin
			vld_s6 <= tok[4].vld;
			vld_s7 <= vld_s6;
			vld_d  <= {vld_d[0], vld_s7};
		end
	end

	always_ff @(posedge clk) begin
		sa_s6   <= sa;
		sb_s6   <= sb;
		quad_s6 <= tok[4].quad;
		unique case (quad_s6)
			2'd0: begin sin_s7 <=  32'(sa_s6); cos_s7 <=  32'(sb_s6); end
			2'd1: begin sin_s7 <=  32'(sb_s6); cos_s7 <= -32'(sa_s6); end
			2'd2: begin sin_s7 <= -32'(sa_s6); cos_s7 <= -32'(sb_s6); end
			default: begin sin_s7 <= -32'(sb_s6); cos_s7 <= 32'(sa_s6); end
		endcase
	end

	eptev_axis u_ax_x (
		.clk(clk), .o(origin_q[19:0]), .a(major_q[19:0]), .b(minor_q[19:0]),
		.c(cos_s7), .s(sin_s7), .pnt(point_x), .tan(tangent_x)
	);
	eptev_axis u_ax_y (
		.clk(clk), .o(origin_q[39:20]), .a(major_q[39:20]), .b(minor_q[39:20]),
		.c(cos_s7), .s(sin_s7), .pnt(point_y), .tan(tangent_y)
	);
	eptev_axis u_ax_z (
		.clk(clk), .o(origin_q[59:40]), .a(major_q[59:40]), .b(minor_q[59:40]),
		.c(cos_s7), .s(sin_s7), .pnt(point_z), .tan(tangent_z)
	);

	assign done = vld_d[1];

	// every beat that is taken raises done, and done never rises without one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##9 done) else $error("result strobe missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 9)) else $error("spurious result strobe");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		tok[4].vld |=> vld_s6) else $error("cell chain valid lost");
endmodule

>>> tb/ellipse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_checker: predicts and checks ellipse point/tangent results
// tracks the three axis registers from config beats, computes the expected
// point and tangent for every accepted angle, compares results in order
// ----------------------------------------------------------------------------
module ellipse_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic [eptev_pkg::AngleWidth-1:0]        angle,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [eptev_pkg::CfgIdxWidth-1:0]       cfg_index,
	input  logic [eptev_pkg::CfgWidth-1:0]          cfg_data,
	input  logic                                   done,
	input  logic signed [eptev_pkg::CoordWidth-1:0] point_x,
	input  logic signed [eptev_pkg::CoordWidth-1:0] point_y,
	input  logic signed [eptev_pkg::CoordWidth-1:0] point_z,
	input  logic signed [eptev_pkg::CoordWidth-1:0] tangent_x,
	input  logic signed [eptev_pkg::CoordWidth-1:0] tangent_y,
	input  logic signed [eptev_pkg::CoordWidth-1:0] tangent_z,
	output int                                     errors,
	output int                                     outstanding
);
	import eptev_pkg::*;

	typedef logic [5:0][CoordWidth-1:0] coords_t;

	localparam longint unsigned QuarterTurn = 64'd1 << FracBits;
	localparam longint unsigned TrigOne     = 64'd1 << 30;

	logic [CfgWidth-1:0] origin_reg;
	logic [CfgWidth-1:0] major_reg;
	logic [CfgWidth-1:0] minor_reg;
	coords_t             pending_results[$];

	// sin(pi/2 * x/2^22) in unsigned q2.30
	function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
		longint unsigned t2;
		longint unsigned acc;
		t2  = (x * x) >> FracBits;
		acc = K9;
		acc = K7 - ((acc * t2) >> FracBits);
		acc = K5 - ((acc * t2) >> FracBits);
		acc = K3 - ((acc * t2) >> FracBits);
		acc = K1 - ((acc * t2) >> FracBits);
		acc = (acc * x) >> FracBits;
		if (acc > TrigOne) acc = TrigOne;
		return acc;
	endfunction

	function automatic longint axis_field(input logic [CfgWidth-1:0] packed_reg, input int idx);
		logic signed [CoordWidth-1:0] f;
		f = packed_reg[idx*CoordWidth +: CoordWidth];
		return longint'(f);
	endfunction

	// floor((v + 2^29) / 2^30)
	function automatic longint q30_to_q12(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic [CoordWidth-1:0] clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (CoordWidth - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[CoordWidth-1:0];
	endfunction

	function automatic coords_t predict_point_tangent(input logic [AngleWidth-1:0] ang);
		logic [23:0]     phase;
		logic [1:0]      quad;
		longint unsigned x;
		longint          sa, sb, s, c, o, a, b;
		coords_t         r;
		phase = 24'(ang) << (24 - AngleWidth);
		quad  = phase[23:22];
		x     = longint'(phase[21:0]);
		sa    = longint'(quarter_sine_q30(x));
		sb    = longint'(quarter_sine_q30(QuarterTurn - x));
		case (quad)
			2'd0: begin s = sa;  c = sb;  end
			2'd1: begin s = sb;  c = -sa; end
			2'd2: begin s = -sa; c = -sb; end
			default: begin s = -sb; c = sa; end
		endcase
		for (int i = 0; i < 3; i++) begin
			o = axis_field(origin_reg, i);
			a = axis_field(major_reg, i);
			b = axis_field(minor_reg, i);
			r[i]     = clamp_coord(o + q30_to_q12(a * c + b * s));
			r[3 + i] = clamp_coord(q30_to_q12(b * c - a * s));
		end
		return r;
	endfunction

	string   field_names[6] = '{"point_x", "point_y", "point_z",
		"tangent_x", "tangent_y", "tangent_z"};
	coords_t seen;
	coords_t want;

	assign outstanding = pending_results.size();
	assign seen = {tangent_z, tangent_y, tangent_x, point_z, point_y, point_x};

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_reg = '0;
			major_reg  = '0;
			minor_reg  = '0;
			errors     = 0;
			pending_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN: origin_reg = cfg_data;
					REG_MAJOR:  major_reg  = cfg_data;
					REG_MINOR:  minor_reg  = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (seen[i] !== want[i]) begin
							$error("%s expected %0d actual %0d", field_names[i],
								$signed(want[i]), $signed(seen[i]));
							errors++;
						end
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(predict_point_tangent(angle));
		end
	end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: ellipse point/tangent evaluator
// directed angles and axis settings at the extremes, then random phases of
// config writes, angle streams, most with random gaps; checking is in checker
// ----------------------------------------------------------------------------
module testbench;
	import eptev_pkg::*;

	localparam logic [CfgIdxWidth-1:0] REG_UNUSED = 2'd3;
	localparam int                      CoordMax   = (1 << (CoordWidth - 1)) - 1;
	localparam int                      CoordMin   = -(1 << (CoordWidth - 1));

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [AngleWidth-1:0]        angle;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CfgIdxWidth-1:0]       cfg_index;
	logic [CfgWidth-1:0]          cfg_data;
	logic                         done;
	logic signed [CoordWidth-1:0] point_x, point_y, point_z;
	logic signed [CoordWidth-1:0] tangent_x, tangent_y, tangent_z;
	int                           errors;
	int                           outstanding;
	bit                           gaps_on;

	ellipse_point_tangent_eval dut (.*);
	ellipse_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("testbench: errors");
		$finish;
	end

	function automatic logic [CoordWidth-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return CoordWidth'(CoordMax);
			1: return CoordWidth'(CoordMin);
			2: return '0;
			3: return CoordWidth'($urandom_range(0, 8191) - 4096);
			default: return CoordWidth'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_axes(input logic [CfgWidth-1:0] o, input logic [CfgWidth-1:0] a,
			input logic [CfgWidth-1:0] b);
		write_reg(REG_ORIGIN, o);
		write_reg(REG_MAJOR, a);
		write_reg(REG_MINOR, b);
	endtask

	function automatic logic [CfgWidth-1:0] random_vector();
		return {pick_coord(), pick_coord(), pick_coord()};
	endfunction

	task automatic send_angle(input logic [AngleWidth-1:0] ang);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		angle <= ang;
		do @(posedge clk); while (busy);
	endtask

	// drain before touching config
	task automatic settle();
		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [AngleWidth-1:0] random_angle();
		if ($urandom_range(0, 3) == 0)
			return AngleWidth'(($urandom_range(0, 3) << (AngleWidth - 2))
				+ $urandom_range(0, 4) - 2);
		return AngleWidth'($urandom);
	endfunction

	logic [AngleWidth-1:0] directed_angles[14] = '{16'h0000, 16'h0001, 16'h3fff, 16'h4000,
		16'h4001, 16'h7fff, 16'h8000, 16'hbfff, 16'hc000, 16'hffff, 16'h2000, 16'h5555,
		16'haaaa, 16'he000};

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		angle     = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		gaps_on   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: all zero
		send_angle(16'h1234);
		settle();
		// saturating ellipse, then a circle, then the most negative corner
		write_axes({3{CoordWidth'(CoordMax)}}, {3{CoordWidth'(CoordMax)}},
			{3{CoordWidth'(CoordMax)}});
		foreach (directed_angles[i]) send_angle(directed_angles[i]);
		settle();
		write_axes(60'd0, {20'd0, 20'd0, 20'sd8192}, {20'd0, 20'sd8192, 20'd0});
		write_reg(REG_UNUSED, {CfgWidth{1'b1}});
		for (int i = 0; i < 8; i++) send_angle(AngleWidth'(i * 8192));
		settle();
		write_axes({3{CoordWidth'(CoordMin)}}, {3{CoordWidth'(CoordMin)}},
			{3{CoordWidth'(CoordMax)}});
		send_angle(16'h0000);
		send_angle(16'h6000);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			gaps_on = (ph != 4);
			write_axes(random_vector(), random_vector(), random_vector());
			if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, random_vector());
			for (int n = 0; n < 150; n++) send_angle(random_angle());
			settle();
		end

		if (errors == 0 && outstanding == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
